/* src/drgb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decibel RGB pixel scaler package
// Shared types, register indexes and pipeline stage positions.
// ---------------------------------------------------------------------------
package drgb_pkg;

	// Default number of fraction bits of the internal dB values.
	localparam int DB_FRAC_BITS_DEF = 8;

	// 10*log10(2) with 28 fraction bits.
	localparam logic [29:0] TEN_LOG10_TWO = 30'd808071242;

	// Configuration register indexes.
	localparam logic [2:0] REG_BLUE_MIN  = 3'd0;
	localparam logic [2:0] REG_BLUE_MAX  = 3'd1;
	localparam logic [2:0] REG_GREEN_MIN = 3'd2;
	localparam logic [2:0] REG_GREEN_MAX = 3'd3;
	localparam logic [2:0] REG_RED_MIN   = 3'd4;
	localparam logic [2:0] REG_RED_MAX   = 3'd5;
	localparam logic [2:0] REG_NOISE     = 3'd6;

	localparam logic [15:0] LIM_MIN_RST = 16'hE200;
	localparam logic [15:0] LIM_MAX_RST = 16'h0000;
	localparam logic [30:0] NOISE_RST   = 31'h322BCC77;

	// Lane stage positions.
	localparam int SQ_STEPS    = 24;
	localparam int DIV_STEPS   = 8;
	localparam int ST_MAG      = 0;
	localparam int ST_NORM     = 1;
	localparam int ST_SQ       = 2;
	localparam int ST_ABS      = ST_SQ + SQ_STEPS;
	localparam int ST_MUL      = ST_ABS + 1;
	localparam int ST_DB       = ST_MUL + 1;
	localparam int ST_NUM      = ST_DB + 1;
	localparam int ST_DIV      = ST_NUM + 1;
	localparam int LANE_STAGES = ST_DIV + DIV_STEPS;

	typedef struct packed {
		logic [31:0] blue_sample;
		logic [31:0] green_sample;
		logic [31:0] red_sample;
		logic        pixel_valid;
	} pixel_t;

	typedef struct packed {
		logic [7:0] blue_byte;
		logic [7:0] green_byte;
		logic [7:0] red_byte;
	} result_t;

	// Display window shared by the lanes.
	typedef struct packed {
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic        [16:0] span;
		logic               ok;
	} window_t;

endpackage

/* src/drgb_window.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Window builder
// Finds the least and greatest of the six channel limits and registers them.
// ---------------------------------------------------------------------------
module drgb_window import drgb_pkg::*; (
	input  logic               clk,
	input  logic signed [15:0] lims [0:5],
	output window_t            win
);

	logic signed [15:0] lo;
	logic signed [15:0] hi;
	logic        [16:0] span;

	// Minimum and maximum over the six limits.
	always_comb begin
		lo = lims[0];
		hi = lims[0];
		for (int i = 1; i < 6; i++) begin
			if (lims[i] < lo) lo = lims[i];
			if (lims[i] > hi) hi = lims[i];
		end
		span = 17'({hi[15], hi} - {lo[15], lo});
	end

	always_ff @(posedge clk) begin
		win.lo   <= lo;
		win.hi   <= hi;
		win.span <= span;
		win.ok   <= hi > lo;
	end

endmodule

/* src/drgb_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Channel lane
// Float magnitude to dB by repeated squaring, window clamp and scaling to a
// byte by a pipelined restoring divider.
// ---------------------------------------------------------------------------
module drgb_lane import drgb_pkg::*; #(
	parameter int DbFracBits = DB_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic [LANE_STAGES-1:0] en,
	input  logic [31:0]            sample,
	input  logic                   keep,
	input  logic [30:0]            noise_floor,
	input  window_t                win,
	output logic [7:0]             level
);

	localparam int DbW   = DbFracBits + 13;
	localparam int RndSh = 52 - DbFracBits;

	// Magnitude raised to the noise floor.
	logic [30:0] mag;
	logic [30:0] mag_s1;
	logic        keep_s1;

	assign mag = (sample[30:0] <= noise_floor) ? noise_floor : sample[30:0];

	always_ff @(posedge clk) begin
		if (en[ST_MAG]) begin
			mag_s1  <= mag;
			keep_s1 <= keep;
		end
	end

	// Normalisation into mantissa and exponent; subnormals are shifted up.
	logic [30:0]       y_s   [0:SQ_STEPS];
	logic [23:0]       fr_s  [0:SQ_STEPS];
	logic signed [8:0] e_s   [0:SQ_STEPS];
	logic              kill_s[0:SQ_STEPS];
	logic [4:0]        msb;
	logic [23:0]       m;
	logic signed [8:0] e;
	logic              zero;

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (mag_s1[i]) msb = 5'(i);
		end
		zero = 1'b0;
		if (mag_s1[30:23] == 8'd0) begin
			zero = mag_s1[22:0] == 23'd0;
			m    = {1'b0, mag_s1[22:0]} << (5'd23 - msb);
			e    = $signed({4'd0, msb}) - 9'sd149;
		end else begin
			m = {1'b1, mag_s1[22:0]};
			e = $signed({1'b0, mag_s1[30:23]}) - 9'sd127;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_NORM]) begin
			y_s[0]    <= {m, 7'd0};
			fr_s[0]   <= 24'd0;
			e_s[0]    <= e;
			kill_s[0] <= zero | ~keep_s1;
		end
	end

	// One squaring step per stage yields one fraction bit of log2.
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;

		assign sq = y_s[k] * y_s[k];
		assign t  = sq[61:30];

		always_ff @(posedge clk) begin
			if (en[ST_SQ + k]) begin
				if (t[31]) begin
					y_s[k+1]  <= t[31:1];
					fr_s[k+1] <= {fr_s[k][22:0], 1'b1};
				end else begin
					y_s[k+1]  <= t[30:0];
					fr_s[k+1] <= {fr_s[k][22:0], 1'b0};
				end
				e_s[k+1]    <= e_s[k];
				kill_s[k+1] <= kill_s[k];
			end
		end
	end

	// Absolute value of the log2 result.
	logic [32:0] l2;
	logic [31:0] abs_s;
	logic        neg_s;
	logic        kill_abs_s;

	assign l2 = {e_s[SQ_STEPS], 24'd0} + {9'd0, fr_s[SQ_STEPS]};

	always_ff @(posedge clk) begin
		if (en[ST_ABS]) begin
			abs_s      <= l2[32] ? 32'(~l2 + 33'd1) : l2[31:0];
			neg_s      <= l2[32];
			kill_abs_s <= kill_s[SQ_STEPS];
		end
	end

	// Scaling by 10*log10(2).
	logic [61:0] prod_s;
	logic        neg_mul_s;
	logic        kill_mul_s;

	always_ff @(posedge clk) begin
		if (en[ST_MUL]) begin
			prod_s     <= abs_s * TEN_LOG10_TWO;
			neg_mul_s  <= neg_s;
			kill_mul_s <= kill_abs_s;
		end
	end

	// Round half away from zero and restore the sign.
	logic [62:0]           rsum;
	logic [DbW-2:0]        rmag;
	logic signed [DbW-1:0] db_s;
	logic                  kill_db_s;

	assign rsum = {1'b0, prod_s} + (63'd1 << (RndSh - 1));
	assign rmag = (DbW-1)'(rsum >> RndSh);

	always_ff @(posedge clk) begin
		if (en[ST_DB]) begin
			db_s      <= neg_mul_s ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
			kill_db_s <= kill_mul_s;
		end
	end

	// Clamp to the window and form 255 times the offset.
	logic signed [DbW-1:0] lo_x;
	logic signed [DbW-1:0] hi_x;
	logic signed [DbW-1:0] dcl;
	logic        [DbW-1:0] dif;
	logic        [24:0]    rem_s [0:DIV_STEPS];
	logic        [7:0]     q_s   [0:DIV_STEPS];
	logic                  kdiv_s[0:DIV_STEPS];

	always_comb begin
		lo_x = {{(DbW-16){win.lo[15]}}, win.lo};
		hi_x = {{(DbW-16){win.hi[15]}}, win.hi};
		dcl  = db_s;
		if (dcl > hi_x) dcl = hi_x;
		if (dcl < lo_x) dcl = lo_x;
		dif  = dcl - lo_x;
	end

	always_ff @(posedge clk) begin
		if (en[ST_NUM]) begin
			rem_s[0]  <= {dif[16:0], 8'd0} - {8'd0, dif[16:0]};
			q_s[0]    <= 8'd0;
			kdiv_s[0] <= kill_db_s;
		end
	end

	// Restoring division by the window span, one quotient bit per stage.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [24:0] cand;

		assign cand = {8'd0, win.span} << (DIV_STEPS - 1 - j);

		always_ff @(posedge clk) begin
			if (en[ST_DIV + j]) begin
				if (rem_s[j] >= cand) begin
					rem_s[j+1] <= rem_s[j] - cand;
					q_s[j+1]   <= {q_s[j][6:0], 1'b1};
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= {q_s[j][6:0], 1'b0};
				end
				kdiv_s[j+1] <= kdiv_s[j];
			end
		end
	end

	assign level = kdiv_s[DIV_STEPS] ? 8'd0 : q_s[DIV_STEPS];

endmodule

/* src/drgb_merge.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result merge
// Joins the three lane bytes into one result and holds it for the receiver.
// ---------------------------------------------------------------------------
module drgb_merge import drgb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       vld,
	input  logic       win_ok,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       res_valid,
	output result_t    res
);

	// Output register; an empty window blacks out the pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load) begin
			res_valid <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res.blue_byte  <= win_ok ? blue  : 8'd0;
			res.green_byte <= win_ok ? green : 8'd0;
			res.red_byte   <= win_ok ? red   : 8'd0;
		end
	end

endmodule

/* src/decibel_rgb_pixel_scaler.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Decibel RGB pixel scaler
// Three float32 channel samples to three window-levelled dB bytes.
// ---------------------------------------------------------------------------
// Usage: pixels enter on the pix channel (valid/ready) and bytes leave on the
// res channel (valid/ready). Three identical lanes, one per colour, each run
// a 38-stage pipeline: magnitude floor, normalisation, 24 squaring stages for
// the log2 fraction, the dB multiply and rounding, the window clamp and an
// 8-stage divider. One pixel per cycle is taken in steady state while the
// receiver does not stall. Configuration writes go through cfg_wr_en,
// cfg_index and cfg_data and are not interlocked with the pipeline; the
// user makes them while no pixel is in flight; the block does not
// enforce this. Reset restores the default window of -30 dB to 0 dB and
// the default noise floor, and empties the pipeline. When the receiver
// stalls, every stage holding an item stays put while empty stages in front
// of it still fill, so ready falls only once the whole pipeline is full.
// ---------------------------------------------------------------------------
module decibel_rgb_pixel_scaler import drgb_pkg::*; #(
	parameter int DB_FRACTION_BITS = DB_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  pixel_t      pix,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	logic signed [15:0]     lims_q [0:5];
	logic [30:0]            noise_q;
	window_t                win;
	logic [LANE_STAGES-1:0] vld_q;
	logic [LANE_STAGES:0]   en;
	logic [7:0]             blue;
	logic [7:0]             green;
	logic [7:0]             red;

	// Configuration registers; limits held as the three minima, then the three maxima, each in blue, green, red order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lims_q[0] <= LIM_MIN_RST;
			lims_q[1] <= LIM_MIN_RST;
			lims_q[2] <= LIM_MIN_RST;
			lims_q[3] <= LIM_MAX_RST;
			lims_q[4] <= LIM_MAX_RST;
			lims_q[5] <= LIM_MAX_RST;
			noise_q   <= NOISE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BLUE_MIN:  lims_q[0] <= cfg_data[15:0];
				REG_GREEN_MIN: lims_q[1] <= cfg_data[15:0];
				REG_RED_MIN:   lims_q[2] <= cfg_data[15:0];
				REG_BLUE_MAX:  lims_q[3] <= cfg_data[15:0];
				REG_GREEN_MAX: lims_q[4] <= cfg_data[15:0];
				REG_RED_MAX:   lims_q[5] <= cfg_data[15:0];
				REG_NOISE:     noise_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	drgb_window u_window (
		.clk  (clk),
		.lims (lims_q),
		.win  (win)
	);

	// Stage load enables: a stage loads when empty or when it moves on.
	always_comb begin
		en[LANE_STAGES] = ~res_valid | res_ready;
		for (int i = LANE_STAGES - 1; i >= 0; i--) begin
			en[i] = ~vld_q[i] | en[i+1];
		end
	end

	assign pix_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < LANE_STAGES; i++) begin
				if (en[i]) vld_q[i] <= (i == 0) ? pix_valid : vld_q[(i == 0) ? 0 : i-1];
			end
		end
	end

	// One lane per colour channel.
	drgb_lane #(.DbFracBits(DB_FRACTION_BITS)) u_lane_blue (
		.clk         (clk),
		.en          (en[LANE_STAGES-1:0]),
		.sample      (pix.blue_sample),
		.keep        (pix.pixel_valid),
		.noise_floor (noise_q),
		.win         (win),
		.level       (blue)
	);

	drgb_lane #(.DbFracBits(DB_FRACTION_BITS)) u_lane_green (
		.clk         (clk),
		.en          (en[LANE_STAGES-1:0]),
		.sample      (pix.green_sample),
		.keep        (pix.pixel_valid),
		.noise_floor (noise_q),
		.win         (win),
		.level       (green)
	);

	drgb_lane #(.DbFracBits(DB_FRACTION_BITS)) u_lane_red (
		.clk         (clk),
		.en          (en[LANE_STAGES-1:0]),
		.sample      (pix.red_sample),
		.keep        (pix.pixel_valid),
		.noise_floor (noise_q),
		.win         (win),
		.level       (red)
	);

	drgb_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (en[LANE_STAGES]),
		.vld       (vld_q[LANE_STAGES-1]),
		.win_ok    (win.ok),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
